@@ rtl/core/usc_pkg.sv @@
// shared constants, types and helpers of the 2x upscaler
package usc_pkg;

    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int COORD_W        = 11;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_IN  = 1'b0,
        REG_HEIGHT_IN = 1'b1
    } t_reg_idx;

    // position of a result relative to the input pixel, per axis
    typedef enum logic [1:0] {
        SLOT_BEFORE = 2'd0,
        SLOT_AT     = 2'd1,
        SLOT_AFTER  = 2'd2
    } t_slot;

    // frame edge flags of one input pixel
    typedef struct packed {
        logic has_up;
        logic has_left;
        logic last_row;
        logic last_col;
    } t_edges;

    function automatic t_slot slot_next(input t_slot s);
        t_slot n;
        unique case (s)
            SLOT_BEFORE: n = SLOT_AT;
            SLOT_AT:     n = SLOT_AFTER;
            default:     n = SLOT_AFTER;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/core/usc_pix_if.sv @@
// input pixel channel
interface usc_pix_if #(
    parameter int PIXEL_BITS = usc_pkg::DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

@@ rtl/core/usc_res_if.sv @@
// output pixel channel with coordinates and markers
interface usc_res_if #(
    parameter int PIXEL_BITS = usc_pkg::DEF_PIXEL_BITS
);
    logic                        valid;
    logic                        ready;
    logic [usc_pkg::COORD_W-1:0] out_row;
    logic [usc_pkg::COORD_W-1:0] out_col;
    logic [PIXEL_BITS-1:0]       pixel_out;
    logic                        run_last;
    logic                        frame_end;

    modport source (output valid, output out_row, output out_col, output pixel_out,
                    output run_last, output frame_end, input ready);
    modport sink   (input valid, input out_row, input out_col, input pixel_out,
                    input run_last, input frame_end, output ready);
endinterface

@@ rtl/core/usc_line_ram.sv @@
// single-port line buffer, read-first, registered read data
module usc_line_ram #(
    parameter int DEPTH  = usc_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = usc_pkg::DEF_PIXEL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // old entry comes out, new pixel goes in at the same address
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/usc_emit.sv @@
// result emitter: steps through the output pixels completed by one input word
module usc_emit #(
    parameter int PIXEL_BITS = usc_pkg::DEF_PIXEL_BITS,
    parameter int CW         = 10,
    parameter int RW         = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_pix,
    input  logic [PIXEL_BITS-1:0] i_left,
    input  logic [PIXEL_BITS-1:0] i_upleft,
    input  logic [PIXEL_BITS-1:0] i_above,
    input  logic [RW-1:0]         i_row,
    input  logic [CW-1:0]         i_col,
    input  usc_pkg::t_edges       i_edges,
    output logic                  o_free,
    usc_res_if.source             o_res
);
    import usc_pkg::*;

    logic                  r_valid;
    t_slot                 r_ri;
    t_slot                 r_ci;
    t_edges                r_edges;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         r_col;
    logic [PIXEL_BITS-1:0] r_p;
    logic [PIXEL_BITS-1:0] r_v;
    logic [PIXEL_BITS-1:0] r_mid;
    logic [PIXEL_BITS-1:0] r_diag;

    logic [PIXEL_BITS:0]   sum_cur;
    logic [PIXEL_BITS:0]   sum_prev;
    logic [PIXEL_BITS:0]   sum_v;
    logic [PIXEL_BITS:0]   sum_diag;
    logic [PIXEL_BITS-1:0] mid_cur;
    logic [PIXEL_BITS-1:0] mid_prev;
    t_slot                 col_start;
    t_slot                 col_end;
    t_slot                 row_end;
    logic                  last;
    logic                  load;
    logic [RW+1:0]         row_full;
    logic [CW+1:0]         col_full;
    logic [RW+1:0]         row_dbl;
    logic [CW+1:0]         col_dbl;

    // floored means of the neighbourhood
    always_comb begin
        sum_cur  = {1'b0, i_left} + {1'b0, i_pix};
        sum_prev = {1'b0, i_upleft} + {1'b0, i_above};
        sum_v    = {1'b0, i_above} + {1'b0, i_pix};
        mid_cur  = sum_cur[PIXEL_BITS:1];
        mid_prev = sum_prev[PIXEL_BITS:1];
        sum_diag = {1'b0, mid_prev} + {1'b0, mid_cur};
    end

    // slot range of the word being emitted
    assign col_start = r_edges.has_left ? SLOT_BEFORE : SLOT_AT;
    assign col_end   = r_edges.last_col ? SLOT_AFTER : SLOT_AT;
    assign row_end   = r_edges.last_row ? SLOT_AFTER : SLOT_AT;
    assign last      = (r_ri == row_end) && (r_ci == col_end);

    assign o_free = !r_valid || (last && o_res.ready);
    assign load   = i_valid && o_free;

    // slot walk: rows outer, columns inner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ri    <= SLOT_AT;
            r_ci    <= SLOT_AT;
        end else if (load) begin
            r_valid <= 1'b1;
            r_ri    <= i_edges.has_up ? SLOT_BEFORE : SLOT_AT;
            r_ci    <= i_edges.has_left ? SLOT_BEFORE : SLOT_AT;
        end else if (r_valid && o_res.ready) begin
            if (last) begin
                r_valid <= 1'b0;
            end else if (r_ci == col_end) begin
                r_ci <= col_start;
                r_ri <= slot_next(r_ri);
            end else begin
                r_ci <= slot_next(r_ci);
            end
        end
    end

    // word payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_edges <= i_edges;
            r_row   <= i_row;
            r_col   <= i_col;
            r_p     <= i_pix;
            r_v     <= sum_v[PIXEL_BITS:1];
            r_mid   <= mid_cur;
            r_diag  <= sum_diag[PIXEL_BITS:1];
        end
    end

    // coordinates in the enlarged frame
    always_comb begin
        row_dbl = {1'b0, r_row, 1'b0};
        col_dbl = {1'b0, r_col, 1'b0};
        case (r_ri)
            SLOT_BEFORE: row_full = row_dbl - 1'b1;
            SLOT_AFTER:  row_full = row_dbl | 1'b1;
            default:     row_full = row_dbl;
        endcase
        case (r_ci)
            SLOT_BEFORE: col_full = col_dbl - 1'b1;
            SLOT_AFTER:  col_full = col_dbl | 1'b1;
            default:     col_full = col_dbl;
        endcase
    end

    // pixel value per slot
    always_comb begin
        case (r_ri)
            SLOT_BEFORE: o_res.pixel_out = (r_ci == SLOT_BEFORE) ? r_diag : r_v;
            default:     o_res.pixel_out = (r_ci == SLOT_BEFORE) ? r_mid : r_p;
        endcase
    end

    assign o_res.valid     = r_valid;
    assign o_res.out_row   = COORD_W'(row_full);
    assign o_res.out_col   = COORD_W'(col_full);
    assign o_res.run_last  = last;
    assign o_res.frame_end = last && r_edges.last_row && r_edges.last_col;

    a_frame_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_end |-> o_res.run_last)
        else $error("frame end flagged on a word that is not the last of its run");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_ri != SLOT_AFTER || r_edges.last_row)
                 && (r_ci != SLOT_AFTER || r_edges.last_col)
                 && (r_ri != SLOT_BEFORE || r_edges.has_up)
                 && (r_ci != SLOT_BEFORE || r_edges.has_left))
        else $error("emitter slot outside the range of its input word");

    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !last |=> r_valid)
        else $error("emitter dropped a run before its last word");

endmodule

@@ rtl/core/image_upscale_2x_averaging.sv @@
// 2x upscaler by averaging: counters, line buffer access and hand-off to the emitter
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+------------------------------------------------
//   i_pix    | in  | valid / ready  | pixel_in
//   o_res    | out | valid / ready  | out_row, out_col, pixel_out, run_last, frame_end
//   i_cfg_*  | in  | write enable   | i_cfg_idx, i_cfg_data
//
// One result word leaves per cycle while o_res is ready; an input word completes
// 1 to 9 results, four on average, which the result emitter steps through.
// First result word is valid once the input word has passed the read stage (line
// buffer read) and been loaded into the emitter register.
// Synchronous active-low reset clears counters, neighbour registers and valid flags;
// the line buffer needs no clearing pass, so input is taken right after reset.
// A stalled output holds the emitter; the next input word waits in the stage behind it.
module image_upscale_2x_averaging #(
    parameter int MAX_WIDTH  = usc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = usc_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = usc_pkg::DEF_PIXEL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [usc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [usc_pkg::CFG_W-1:0]     i_cfg_data,
    usc_pix_if.sink                       i_pix,
    usc_res_if.source                     o_res
);
    import usc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0]      r_width_in;
    logic [CFG_W-1:0]      r_height_in;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [PIXEL_BITS-1:0] r_prev_pix;
    logic [PIXEL_BITS-1:0] r_prev_above;
    logic                  r_b_valid;
    logic [PIXEL_BITS-1:0] r_b_pix;
    logic [PIXEL_BITS-1:0] r_b_left;
    logic [CW-1:0]         r_b_col;
    logic [RW-1:0]         r_b_row;
    t_edges                r_b_edges;

    logic [CW-1:0]         last_col_idx;
    logic [RW-1:0]         last_row_idx;
    logic [CW-1:0]         cur_col;
    logic [RW-1:0]         cur_row;
    t_edges                cur_edges;
    logic                  accept;
    logic                  emit_free;
    logic                  b_take;
    logic [PIXEL_BITS-1:0] above;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_in  <= CFG_DIM_RESET;
            r_height_in <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH_IN:  r_width_in  <= i_cfg_data;
                REG_HEIGHT_IN: r_height_in <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped last column and row
    always_comb begin
        if (r_width_in == '0) begin
            last_col_idx = '0;
        end else if (32'(r_width_in) > MAX_WIDTH) begin
            last_col_idx = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = CW'(32'(r_width_in) - 32'd1);
        end
        if (r_height_in == '0) begin
            last_row_idx = '0;
        end else if (32'(r_height_in) > MAX_HEIGHT) begin
            last_row_idx = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row_idx = RW'(32'(r_height_in) - 32'd1);
        end
    end

    // position of the incoming word, saturated to the frame
    always_comb begin
        cur_col            = (r_col > last_col_idx) ? last_col_idx : r_col;
        cur_row            = (r_row > last_row_idx) ? last_row_idx : r_row;
        cur_edges.has_up   = (cur_row != '0);
        cur_edges.has_left = (cur_col != '0);
        cur_edges.last_row = (cur_row == last_row_idx);
        cur_edges.last_col = (cur_col == last_col_idx);
    end

    assign b_take      = r_b_valid && emit_free;
    assign i_pix.ready = !r_b_valid || emit_free;
    assign accept      = i_pix.valid && i_pix.ready;

    // line buffer: read the pixel above, store the new one
    usc_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (cur_col),
        .i_wdata (i_pix.pixel_in),
        .o_rdata (above)
    );

    // counters, neighbour registers and the read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_prev_pix   <= '0;
            r_prev_above <= '0;
            r_b_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_prev_pix <= i_pix.pixel_in;
                if (cur_edges.last_col) begin
                    r_col <= '0;
                    r_row <= cur_edges.last_row ? '0 : cur_row + 1'b1;
                end else begin
                    r_col <= cur_col + 1'b1;
                    r_row <= cur_row;
                end
            end
            if (b_take) begin
                r_prev_above <= above;
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_take) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix   <= i_pix.pixel_in;
            r_b_left  <= r_prev_pix;
            r_b_col   <= cur_col;
            r_b_row   <= cur_row;
            r_b_edges <= cur_edges;
        end
    end

    usc_emit #(
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .RW         (RW)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_b_valid),
        .i_pix    (r_b_pix),
        .i_left   (r_b_left),
        .i_upleft (r_prev_above),
        .i_above  (above),
        .i_row    (r_b_row),
        .i_col    (r_b_col),
        .i_edges  (r_b_edges),
        .o_free   (emit_free),
        .o_res    (o_res)
    );

endmodule

@@ tb/tb_image_upscale_2x_averaging.sv @@
// self-checking testbench of the 2x averaging upscaler: directed table, random frames, stalls
module tb_image_upscale_2x_averaging;
    import usc_pkg::*;

    localparam int RAND_WORDS  = 270;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int STEP_COUNT  = 35;

    // one expected result word
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [7:0]         pix;
        logic               run_last;
        logic               frame_end;
    } t_out_word;

    typedef enum bit {STEP_CFG, STEP_PIX} t_step_kind;

    // one row of the directed table; last_word is typed in only where typed is set
    typedef struct {
        t_step_kind       kind;
        logic [CFG_W-1:0] width_val;
        logic [CFG_W-1:0] height_val;
        logic [7:0]       pix;
        bit               typed;
        t_out_word        last_word;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    usc_pix_if pix_ch ();
    usc_res_if res_ch ();

    image_upscale_2x_averaging dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    // directed table: extremes, clamped registers, mid-frame changes, width and height one
    t_step directed_seq [STEP_COUNT] = '{
        '{STEP_PIX, 11'd0,    11'd0,    8'h00, 1'b1, '{11'd0, 11'd0, 8'h00, 1'b1, 1'b0}},
        '{STEP_PIX, 11'd0,    11'd0,    8'hFF, 1'b1, '{11'd0, 11'd2, 8'hFF, 1'b1, 1'b0}},
        '{STEP_PIX, 11'd0,    11'd0,    8'hAA, 1'b0, '0},
        '{STEP_CFG, 11'd0,    11'd1024, 8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h55, 1'b1, '{11'd0, 11'd1, 8'h55, 1'b1, 1'b0}},
        '{STEP_CFG, 11'd0,    11'd0,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h80, 1'b1, '{11'd1, 11'd1, 8'h80, 1'b1, 1'b1}},
        '{STEP_CFG, 11'd2,    11'd2,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hFF, 1'b1, '{11'd0, 11'd0, 8'hFF, 1'b1, 1'b0}},
        '{STEP_PIX, 11'd0,    11'd0,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h01, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hFE, 1'b1, '{11'd3, 11'd3, 8'hFE, 1'b1, 1'b1}},
        '{STEP_CFG, 11'd3,    11'd3,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h12, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h34, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h56, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h78, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h9A, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hBC, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hDE, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hF0, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h0F, 1'b1, '{11'd5, 11'd5, 8'h0F, 1'b1, 1'b1}},
        '{STEP_CFG, 11'd2047, 11'd2047, 8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h7F, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hC3, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h3C, 1'b0, '0},
        '{STEP_CFG, 11'd1,    11'd1,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h01, 1'b1, '{11'd1, 11'd1, 8'h01, 1'b1, 1'b1}},
        '{STEP_CFG, 11'd4,    11'd2,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hFF, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'hFF, 1'b0, '0},
        '{STEP_CFG, 11'd4,    11'd1,    8'h00, 1'b0, '0},
        '{STEP_PIX, 11'd0,    11'd0,    8'h81, 1'b0, '0}
    };

    // predictor state
    logic [7:0]       line_mirror  [DEF_MAX_WIDTH];
    bit               line_written [DEF_MAX_WIDTH];
    logic [7:0]       left_px;
    logic [7:0]       upleft_px;
    int unsigned      at_row;
    int unsigned      at_col;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    t_out_word awaited_px [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_req;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned fail_count;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned frames_closed;
    int unsigned widest;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    function automatic logic [7:0] mean2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    function automatic t_out_word make_word(input int unsigned r, input int unsigned c,
                                            input logic [7:0] p);
        t_out_word o;
        o = '0;
        o.row = r[COORD_W-1:0];
        o.col = c[COORD_W-1:0];
        o.pix = p;
        return o;
    endfunction

    // a width change is harmless unless it makes a later row read never-written line entries
    function automatic bit store_covers(input int unsigned w_new, input int unsigned h_new);
        int unsigned r;
        r = (at_row > h_new - 1) ? h_new - 1 : at_row;
        if (r == 0) return 1'b1;
        for (int i = 0; i < w_new; i++)
            if (!line_written[i]) return 1'b0;
        return 1'b1;
    endfunction

    // expected output pixels completed by one input pixel, in emission order
    task automatic expand_pixel(input logic [7:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        bit          lc;
        bit          lr;
        logic [7:0]  above;
        logic [7:0]  mid_cur;
        logic [7:0]  mid_prev;
        logic [7:0]  vert;
        w = eff_dim(width_reg, DEF_MAX_WIDTH);
        h = eff_dim(height_reg, DEF_MAX_HEIGHT);
        c = (at_col > w - 1) ? w - 1 : at_col;
        r = (at_row > h - 1) ? h - 1 : at_row;
        lc = (c == w - 1);
        lr = (r == h - 1);
        above = line_mirror[c];
        mid_cur = mean2(left_px, p);
        mid_prev = mean2(upleft_px, above);
        // odd row above this input
        if (r >= 1) begin
            vert = mean2(above, p);
            if (c >= 1) awaited_px.push_back(make_word(2*r - 1, 2*c - 1, mean2(mid_prev, mid_cur)));
            awaited_px.push_back(make_word(2*r - 1, 2*c, vert));
            if (lc) awaited_px.push_back(make_word(2*r - 1, 2*c + 1, vert));
        end
        // even row of this input
        if (c >= 1) awaited_px.push_back(make_word(2*r, 2*c - 1, mid_cur));
        awaited_px.push_back(make_word(2*r, 2*c, p));
        if (lc) awaited_px.push_back(make_word(2*r, 2*c + 1, p));
        // bottom row copies the one above
        if (lr) begin
            if (c >= 1) awaited_px.push_back(make_word(2*r + 1, 2*c - 1, mid_cur));
            awaited_px.push_back(make_word(2*r + 1, 2*c, p));
            if (lc) awaited_px.push_back(make_word(2*r + 1, 2*c + 1, p));
        end
        awaited_px[awaited_px.size()-1].run_last = 1'b1;
        if (lr && lc) awaited_px[awaited_px.size()-1].frame_end = 1'b1;
        // advance state
        line_mirror[c] = p;
        line_written[c] = 1'b1;
        upleft_px = above;
        left_px = p;
        if (lc) begin
            at_col = 0;
            at_row = lr ? 0 : r + 1;
        end else begin
            at_col = c + 1;
            at_row = r;
        end
    endtask

    // offer one word, idling at random first; valid stays high after acceptance
    task automatic send_word(input logic [7:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            if (pix_ch.valid) pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_in <= p;
        do @(posedge i_clk); while (!pix_ch.ready);
        expand_pixel(p);
        words_in++;
    endtask

    // stop offering and wait until every awaited word has come back
    task automatic settle();
        if (pix_ch.valid) pix_ch.valid <= 1'b0;
        while (awaited_px.size() != 0) @(posedge i_clk);
    endtask

    // write the width register, then the height register
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_WIDTH_IN;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx <= REG_HEIGHT_IN;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
        if (eff_dim(w, DEF_MAX_WIDTH) > widest) widest = eff_dim(w, DEF_MAX_WIDTH);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim(input int unsigned span);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50) return CFG_W'($urandom_range(4, 1));
        if (sel < 85) return CFG_W'($urandom_range(span, 5));
        if (sel < 92) return '0;
        if (sel < 96) return CFG_W'($urandom_range(2047, 1024));
        return CFG_W'($urandom_range(3 * span, span + 1));
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_word();
        t_out_word want;
        if (awaited_px.size() == 0) begin
            $error("result word with nothing awaited: row %0d col %0d",
                   res_ch.out_row, res_ch.out_col);
            fail_count++;
        end else begin
            want = awaited_px.pop_front();
            check_field("out_row", 32'(want.row), 32'(res_ch.out_row));
            check_field("out_col", 32'(want.col), 32'(res_ch.out_col));
            check_field("pixel_out", 32'(want.pix), 32'(res_ch.pixel_out));
            check_field("run_last", 32'(want.run_last), 32'(res_ch.run_last));
            check_field("frame_end", 32'(want.frame_end), 32'(res_ch.frame_end));
            if (res_ch.frame_end) frames_closed++;
            words_out++;
        end
    endtask

    // result side: check accepted words, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) check_word();
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned random_words;
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned rest;
        int unsigned n;
        int unsigned sel;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        bit force_full;

        // known values from time zero
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_WIDTH_IN;
        i_cfg_data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_in = '0;
        res_ch.ready = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        fail_count = 0;
        words_in = 0;
        words_out = 0;
        frames_closed = 0;
        widest = DEF_MAX_WIDTH;
        random_words = 0;

        // predictor after reset
        foreach (line_mirror[i]) begin
            line_mirror[i] = '0;
            line_written[i] = 1'b0;
        end
        left_px = '0;
        upleft_px = '0;
        at_row = 0;
        at_col = 0;
        width_reg = CFG_DIM_RESET;
        height_reg = CFG_DIM_RESET;

        send_idle_pct = 26;
        recv_idle_pct = 67;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_seq[i]) begin
            if (directed_seq[i].kind == STEP_CFG) begin
                settle();
                set_frame(directed_seq[i].width_val, directed_seq[i].height_val);
            end else begin
                send_word(directed_seq[i].pix);
                if (directed_seq[i].typed)
                    awaited_px[awaited_px.size()-1] = directed_seq[i].last_word;
            end
        end

        // random frames, mostly complete, some cut short and reconfigured mid-frame
        while (random_words < RAND_WORDS) begin
            if (random_words < RAND_WORDS / 3) begin
                send_idle_pct = 26;
                recv_idle_pct = 67;
            end else if (random_words < 2 * RAND_WORDS / 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wv = pick_dim(12);
            hv = pick_dim(6);
            force_full = 1'b0;
            // long output stall while a whole frame is offered back to back
            if (random_words >= 2 * RAND_WORDS / 3 && !hold_req && at_row == 0) begin
                wv = 11'd8;
                hv = 11'd4;
                force_full = 1'b1;
            end
            settle();
            if (!store_covers(eff_dim(wv, DEF_MAX_WIDTH), eff_dim(hv, DEF_MAX_HEIGHT)))
                wv = width_reg;
            set_frame(wv, hv);
            if (force_full) hold_req = 1'b1;
            w = eff_dim(wv, DEF_MAX_WIDTH);
            h = eff_dim(hv, DEF_MAX_HEIGHT);
            r = (at_row > h - 1) ? h - 1 : at_row;
            c = (at_col > w - 1) ? w - 1 : at_col;
            rest = w * h - (r * w + c);
            if (force_full || (rest <= 80 && $urandom_range(99) < 75))
                n = rest;
            else
                n = $urandom_range((rest < 30) ? rest : 30, 1);
            repeat (n) begin
                sel = $urandom_range(99);
                if (sel < 15)
                    send_word(8'h00);
                else if (sel < 30)
                    send_word(8'hFF);
                else
                    send_word(8'($urandom_range(255)));
                random_words++;
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d input words gave %0d checked result words over %0d closed frames",
                 words_in, words_out, frames_closed);
        $display("widths up to %0d, clamped and mid-frame register changes, one long stall",
                 widest);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/usc_pkg.sv
rtl/core/usc_pix_if.sv
rtl/core/usc_res_if.sv
rtl/core/usc_line_ram.sv
rtl/core/usc_emit.sv
rtl/core/image_upscale_2x_averaging.sv
tb/tb_image_upscale_2x_averaging.sv
